>>> rtl/core/tat_pkg.sv
// Shared types, widths and the arctangent table for the tilt-angle block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tat_pkg;

    localparam int RAD_W    = 64;  // radicand width after guard shift
    localparam int ROOT_W   = 32;  // square-root width
    localparam int CW       = 36;  // CORDIC x/y width (room for gain)
    localparam int ZW       = 32;  // angle accumulator width
    localparam int TAB_FRAC = 24;  // fraction bits of the angle table
    localparam int TAB_LEN  = 24;  // entries in the angle table
    localparam int OUT_W    = 16;  // result angle width

    typedef struct packed {
        logic [OUT_W-1:0] roll;
        logic [OUT_W-1:0] pitch;
    } tat_result_t;

    // atan(2^-idx) in degrees with TAB_FRAC fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 32'sd754974720;
            1:       v = 32'sd445687602;
            2:       v = 32'sd235489088;
            3:       v = 32'sd119537938;
            4:       v = 32'sd60000934;
            5:       v = 32'sd30029717;
            6:       v = 32'sd15018523;
            7:       v = 32'sd7509720;
            8:       v = 32'sd3754917;
            9:       v = 32'sd1877466;
            10:      v = 32'sd938734;
            11:      v = 32'sd469367;
            12:      v = 32'sd234684;
            13:      v = 32'sd117342;
            14:      v = 32'sd58671;
            15:      v = 32'sd29335;
            16:      v = 32'sd14668;
            17:      v = 32'sd7334;
            18:      v = 32'sd3667;
            19:      v = 32'sd1833;
            20:      v = 32'sd917;
            21:      v = 32'sd458;
            22:      v = 32'sd229;
            23:      v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/accel_tilt_angle_top.sv
// Accelerometer tilt angle block: roll and pitch from one three-axis sample.
// Depends on tat_pkg, tat_isqrt, tat_cordic and tat_out_buf.
//
// Usage:
//   Input channel s_valid/s_ready carries accel_x, accel_y, accel_z as signed
//   raw counts. Result channel m_valid/m_ready carries roll_deg and pitch_deg,
//   signed degrees with ANGLE_FRAC_BITS fraction bits, clamped to +/-90.
//   Throughput: one transfer in and one out every cycle while m_ready is high.
//   Pipeline from input transfer to m_valid: squares, sums, square root
//   (one bit per stage), CORDIC load, CORDIC_STAGES rotations (at most 24),
//   rounding, result buffer.
//   Reset (aresetn low, synchronous) clears every valid bit; no item is in
//   flight afterward. There is no configuration.
//   Stall: a two-entry result buffer absorbs results while m_ready is low;
//   the whole pipeline holds only when a finished result meets a full
//   buffer, and then s_ready drops. Nothing is lost or repeated.
`timescale 1ns / 1ps

module accel_tilt_angle_top #(
    parameter int SAMPLE_BITS     = 16,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] s_accel_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [tat_pkg::OUT_W-1:0] m_roll_deg,
    output logic signed [tat_pkg::OUT_W-1:0] m_pitch_deg
);
    import tat_pkg::*;

    localparam int GUARD = 32 - SAMPLE_BITS;
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int NUM_W = SAMPLE_BITS + 1;

    logic en;

    // stage A: squares and numerators
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic signed [NUM_W-1:0] na_roll_reg, na_pitch_reg;
    logic                    va_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg      <= SQ_W'(s_accel_x) * SQ_W'(s_accel_x);
            sqy_reg      <= SQ_W'(s_accel_y) * SQ_W'(s_accel_y);
            sqz_reg      <= SQ_W'(s_accel_z) * SQ_W'(s_accel_z);
            na_roll_reg  <= {s_accel_y[SAMPLE_BITS-1], s_accel_y};
            na_pitch_reg <= -$signed({s_accel_x[SAMPLE_BITS-1], s_accel_x});
        end
    end

    // stage B: sums of squares with guard shift
    logic [RAD_W-1:0]        rad_roll_reg, rad_pitch_reg;
    logic signed [NUM_W-1:0] nb_roll_reg, nb_pitch_reg;
    logic                    vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_roll_reg  <= {sqx_reg + sqz_reg, {(2*GUARD){1'b0}}};
            rad_pitch_reg <= {sqy_reg + sqz_reg, {(2*GUARD){1'b0}}};
            nb_roll_reg   <= na_roll_reg;
            nb_pitch_reg  <= na_pitch_reg;
        end
    end

    // square roots, numerators ride along
    logic              sr_roll_v, sr_pitch_v;
    logic [ROOT_W-1:0] root_roll, root_pitch;
    logic [NUM_W-1:0]  num_roll, num_pitch;

    tat_isqrt #(.PAY_W(NUM_W)) u_sqrt_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vb_reg), .in_rad(rad_roll_reg), .in_pay(nb_roll_reg),
        .out_valid(sr_roll_v), .out_root(root_roll), .out_pay(num_roll)
    );

    tat_isqrt #(.PAY_W(NUM_W)) u_sqrt_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vb_reg), .in_rad(rad_pitch_reg), .in_pay(nb_pitch_reg),
        .out_valid(sr_pitch_v), .out_root(root_pitch), .out_pay(num_pitch)
    );

    // arctangent lanes
    logic             roll_v, pitch_v;
    logic [OUT_W-1:0] roll_angle, pitch_angle;

    tat_cordic #(
        .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sr_roll_v), .in_root(root_roll), .in_num($signed(num_roll)),
        .out_valid(roll_v), .out_angle(roll_angle)
    );

    tat_cordic #(
        .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cordic_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sr_pitch_v), .in_root(root_pitch), .in_num($signed(num_pitch)),
        .out_valid(pitch_v), .out_angle(pitch_angle)
    );

    // result buffer; hold the pipeline only when a result meets a full buffer
    logic        buf_full;
    tat_result_t res_in, res_out;

    assign res_in = '{roll: roll_angle, pitch: pitch_angle};
    assign en      = !(roll_v && buf_full);
    assign s_ready = en;

    tat_out_buf u_out_buf (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(roll_v), .in_data(res_in), .full(buf_full),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(res_out)
    );

    assign m_roll_deg  = $signed(res_out.roll);
    assign m_pitch_deg = $signed(res_out.pitch);

    // the two lanes stay in lockstep
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        roll_v == pitch_v)
        else $error("roll and pitch lanes out of step");

    // input stalls only while a finished result waits with the buffer full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (roll_v && m_valid))
        else $error("input stalled without a waiting result");

    // with no finished result waiting, the pipeline is never held
    a_no_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !roll_v |-> s_ready)
        else $error("pipeline held with an empty last stage");

endmodule

>>> rtl/core/tat_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on tat_pkg; carries a side payload alongside the root.
`timescale 1ns / 1ps

module tat_isqrt #(
    parameter int PAY_W = 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [tat_pkg::RAD_W-1:0] in_rad,
    input  logic [PAY_W-1:0]          in_pay,
    output logic                      out_valid,
    output logic [tat_pkg::ROOT_W-1:0] out_root,
    output logic [PAY_W-1:0]          out_pay
);
    import tat_pkg::*;

    localparam int STEPS = ROOT_W;

    logic [RAD_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    logic [PAY_W-1:0]  pay_reg  [STEPS];
    logic              valid_reg [STEPS];

    logic [RAD_W-1:0]  rem_in  [STEPS];
    logic [ROOT_W-1:0] root_in [STEPS];
    logic [PAY_W-1:0]  pay_in  [STEPS];
    logic              valid_in [STEPS];

    assign rem_in[0]   = in_rad;
    assign root_in[0]  = '0;
    assign pay_in[0]   = in_pay;
    assign valid_in[0] = in_valid;

    genvar s;
    generate
        for (s = 0; s < STEPS; s++) begin : g_step
            localparam int K = STEPS - 1 - s;
            logic [RAD_W:0]    trial;
            logic              fits;
            logic [RAD_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (s > 0) begin : g_link
                assign rem_in[s]   = rem_reg[s-1];
                assign root_in[s]  = root_reg[s-1];
                assign pay_in[s]   = pay_reg[s-1];
                assign valid_in[s] = valid_reg[s-1];
            end

            // try setting bit K of the root against the remainder
            always_comb begin
                trial     = ((RAD_W+1)'(root_in[s]) << (K + 1))
                          + ((RAD_W+1)'(1) << (2 * K));
                fits      = {1'b0, rem_in[s]} >= trial;
                rem_next  = fits ? (rem_in[s] - trial[RAD_W-1:0]) : rem_in[s];
                root_next = fits ? (root_in[s] | (ROOT_W'(1) << K)) : root_in[s];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (en) begin
                    valid_reg[s] <= valid_in[s];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    pay_reg[s]  <= pay_in[s];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_pay   = pay_reg[STEPS-1];

endmodule

>>> rtl/core/tat_cordic.sv
// Pipelined vectoring CORDIC giving atan2(num, root) in degrees, then
// rounding and clamping to +/-90. Depends on tat_pkg.
`timescale 1ns / 1ps

module tat_cordic #(
    parameter int SAMPLE_BITS     = 16,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tat_pkg::ROOT_W-1:0]  in_root,
    input  logic signed [SAMPLE_BITS:0] in_num,
    output logic                        out_valid,
    output logic [tat_pkg::OUT_W-1:0]   out_angle
);
    import tat_pkg::*;

    localparam int GUARD  = 32 - SAMPLE_BITS;
    localparam int N      = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int RND_SH = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] LIM  = ZW'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [ZW-1:0] HALF = ZW'(2 ** (RND_SH - 1));

    typedef struct packed {
        logic zero;  // root was zero
        logic pos;   // numerator positive
        logic neg;   // numerator negative
    } tat_flag_t;

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    tat_flag_t            flg_reg [N+1];
    logic                 v_reg [N+1];

    logic [tat_pkg::OUT_W-1:0] angle_reg;
    logic                      out_v_reg;

    // load root as x, guard-shifted numerator as y
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]      <= $signed({{(CW-ROOT_W){1'b0}}, in_root});
            y_reg[0]      <= $signed({{(CW-SAMPLE_BITS-1){in_num[SAMPLE_BITS]}}, in_num})
                             <<< GUARD;
            z_reg[0]      <= '0;
            flg_reg[0]    <= '{zero: (in_root == '0), pos: (in_num > 0), neg: in_num[SAMPLE_BITS]};
        end
    end

    genvar i;
    generate
        for (i = 1; i <= N; i++) begin : g_rot
            logic signed [CW-1:0] dx, dy;
            logic                 up;

            assign dx = y_reg[i-1] >>> (i - 1);
            assign dy = x_reg[i-1] >>> (i - 1);
            assign up = y_reg[i-1] > 0;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end

            // rotate toward y = 0 and accumulate the angle
            always_ff @(posedge aclk) begin
                if (en) begin
                    flg_reg[i] <= flg_reg[i-1];
                    if (up) begin
                        x_reg[i] <= x_reg[i-1] + dx;
                        y_reg[i] <= y_reg[i-1] - dy;
                        z_reg[i] <= z_reg[i-1] + atan_deg(i - 1);
                    end else begin
                        x_reg[i] <= x_reg[i-1] - dx;
                        y_reg[i] <= y_reg[i-1] + dy;
                        z_reg[i] <= z_reg[i-1] - atan_deg(i - 1);
                    end
                end
            end
        end
    endgenerate

    // round half up, clamp, and pick the fixed answer for a zero root
    logic signed [ZW-1:0] rounded, clamped, angle_next;
    always_comb begin
        rounded = (z_reg[N] + HALF) >>> RND_SH;
        if (rounded > LIM) begin
            clamped = LIM;
        end else if (rounded < -LIM) begin
            clamped = -LIM;
        end else begin
            clamped = rounded;
        end
        if (flg_reg[N].zero) begin
            angle_next = flg_reg[N].pos ? LIM : (flg_reg[N].neg ? -LIM : '0);
        end else begin
            angle_next = clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next[OUT_W-1:0];
        end
    end

    assign out_valid = out_v_reg;
    assign out_angle = angle_reg;

endmodule

>>> rtl/core/tat_out_buf.sv
// Two-entry result buffer between the pipeline and the result channel.
// Depends on tat_pkg for the result type.
`timescale 1ns / 1ps

module tat_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  tat_pkg::tat_result_t in_data,
    output logic                 full,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tat_pkg::tat_result_t m_data
);
    import tat_pkg::*;

    logic [1:0]  count_reg, count_next;
    tat_result_t head_reg, head_next;
    tat_result_t tail_reg, tail_next;
    logic        push, pop;

    assign full    = count_reg == 2'd2;
    assign push    = in_valid && !full;
    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != 2'd0;
    assign m_data  = head_reg;

    // advance head on a transfer out, append new results behind it
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = in_data;
                end else begin
                    tail_next = in_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = in_data;
                end else begin
                    head_next = tail_reg;
                    tail_next = in_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
